[rtl/core/assert_macros.svh]
// Assertion macros used by the allocator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, masked during reset
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, masked during reset
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

[rtl/core/ffha_pkg.sv]
// Package: constants, header entry type and status codes of the allocator
package ffha_pkg;
   localparam int PoolBytes   = 4096;
   localparam int HeaderBytes = 24;
   localparam int Ng          = PoolBytes / 8;
   localparam int HdrG        = (HeaderBytes + 7) / 8;
   localparam int GW          = $clog2(Ng);
   localparam int SW          = GW + 1;
   localparam int MaxReq      = PoolBytes - HdrG * 8;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_SIZE  = 3'd1;
   localparam logic [2:0] ST_NO_FIT    = 3'd2;
   localparam logic [2:0] ST_NULL_FREE = 3'd3;
   localparam logic [2:0] ST_DBL_FREE  = 3'd4;
   localparam logic [2:0] ST_NOT_BLOCK = 3'd5;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef struct packed {
      logic          mark;
      logic          freeb;
      logic [SW-1:0] sizeg;
      logic [GW-1:0] nxt;
      logic          nxt_ok;
   } hdr_type;
endpackage

[rtl/core/first_fit_heap_allocator.sv]
// Top level: first-fit heap allocator with address-sorted free list and merging
//
//  channel | direction | ports
//  req     | in        | req_valid req_ready req_cmd req_request_bytes req_payload_offset
//  rsp     | out       | rsp_valid rsp_ready rsp_granted_offset rsp_status
//
// One request at a time. A clearing pass over all Ng (512) header entries after
// reset zeroes the header store and writes one free block at entry 0; no request
// is taken meanwhile. Each request walks the free list through the single
// header-store read port, then checks and updates headers, so its time grows with the list length.
// A result waits in its register while rsp_ready is low; the next request is
// taken only after it leaves.
`include "assert_macros.svh"
module first_fit_heap_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [15:0] req_request_bytes,
   input  logic [11:0] req_payload_offset,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_granted_offset,
   output logic [2:0]  rsp_status
);
   localparam int GW = ffha_pkg::GW;
   localparam int SW = ffha_pkg::SW;
   localparam logic [GW-1:0] HDR = GW'(ffha_pkg::HdrG);

   localparam logic [4:0] S_CLR   = 5'd0;
   localparam logic [4:0] S_IDLE  = 5'd1;
   localparam logic [4:0] S_ARD   = 5'd2;   // alloc: read cur
   localparam logic [4:0] S_AWT   = 5'd3;   // alloc: check cur
   localparam logic [4:0] S_ASPL  = 5'd4;   // alloc: unused; the split block is written in S_AWT
   localparam logic [4:0] S_ACUR  = 5'd5;   // alloc: write cur
   localparam logic [4:0] S_APRD  = 5'd6;   // alloc: read prev
   localparam logic [4:0] S_APWT  = 5'd7;
   localparam logic [4:0] S_FRD   = 5'd8;   // free: read h
   localparam logic [4:0] S_FWT   = 5'd9;
   localparam logic [4:0] S_WRD   = 5'd10;  // free: walk read
   localparam logic [4:0] S_WWT   = 5'd11;
   localparam logic [4:0] S_NRD   = 5'd12;  // free: read successor cur
   localparam logic [4:0] S_NWT   = 5'd13;
   localparam logic [4:0] S_HWR   = 5'd14;  // free: h becomes the last list entry
   localparam logic [4:0] S_PRD   = 5'd15;  // free: read prev
   localparam logic [4:0] S_PWT   = 5'd16;
   localparam logic [4:0] S_PWR2  = 5'd17;  // free: clear h after merge
   localparam logic [4:0] S_HWR2  = 5'd19;  // free: write h, after cur is cleared on a merge

   logic [4:0]    state_ff, state_in;
   logic [GW-1:0] clr_ff, clr_in;
   logic [GW-1:0] head_ff, head_in;
   logic          empty_ff, empty_in;
   logic [GW-1:0] cur_ff, cur_in, prev_ff, prev_in, h_ff, h_in;
   logic          hasp_ff, hasp_in, curok_ff, curok_in;
   logic [SW-1:0] need_ff, need_in;
   ffha_pkg::hdr_type c_ff, c_in, hh_ff, hh_in;
   logic [11:0]   goff_ff, goff_in;
   logic [2:0]    stat_ff, stat_in;
   logic          rv_ff, rv_in;

   logic              wr_en;
   logic [GW-1:0]     wr_addr, rd_addr;
   ffha_pkg::hdr_type wr_data, rd_data;

   ffha_hdr_ram u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_ready          = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_valid          = rv_ff;
   assign rsp_granted_offset = goff_ff;
   assign rsp_status         = stat_ff;

   logic [SW+1:0] nbsz;
   logic [GW+SW:0] hend, pend;
   logic [GW:0]   hq;
   always_comb begin
      nbsz = {2'b0, rd_data.sizeg} - {2'b0, need_ff} - (SW+2)'(ffha_pkg::HdrG);
      hend = (GW+SW+1)'(h_ff) + (GW+SW+1)'(ffha_pkg::HdrG) + (GW+SW+1)'(hh_ff.sizeg);
      pend = (GW+SW+1)'(prev_ff) + (GW+SW+1)'(ffha_pkg::HdrG) + (GW+SW+1)'(rd_data.sizeg);
      hq   = (GW+1)'(req_payload_offset[11:3]) - (GW+1)'(ffha_pkg::HdrG);
   end

   // sequencer
   always_comb begin
      state_in = state_ff; clr_in = clr_ff; head_in = head_ff; empty_in = empty_ff;
      cur_in = cur_ff; prev_in = prev_ff; h_in = h_ff; hasp_in = hasp_ff;
      curok_in = curok_ff; need_in = need_ff; c_in = c_ff; hh_in = hh_ff;
      goff_in = goff_ff; stat_in = stat_ff; rv_in = rv_ff;
      wr_en = 1'b0; wr_addr = cur_ff; wr_data = c_ff; rd_addr = cur_ff;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (state_ff)
         S_CLR: begin
            wr_en = 1'b1; wr_addr = clr_ff; wr_data = '0;
            if (clr_ff == '0) begin
               wr_data.mark = 1'b1; wr_data.freeb = 1'b1;
               wr_data.sizeg = SW'(ffha_pkg::Ng - ffha_pkg::HdrG);
            end
            clr_in = clr_ff + 1'b1;
            if (clr_ff == GW'(ffha_pkg::Ng - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid && req_ready) begin
               goff_in = '0; hasp_in = 1'b0; cur_in = head_ff;
               if (req_cmd == ffha_pkg::CMD_ALLOC) begin
                  need_in = SW'(({1'b0, req_request_bytes} + 17'd7) >> 3);
                  if (req_request_bytes == 16'd0 ||
                      req_request_bytes > 16'(ffha_pkg::MaxReq)) begin
                     stat_in = ffha_pkg::ST_BAD_SIZE; rv_in = 1'b1;
                  end else if (empty_ff) begin
                     stat_in = ffha_pkg::ST_NO_FIT; rv_in = 1'b1;
                  end else state_in = S_ARD;
               end else begin
                  h_in = hq[GW-1:0];
                  if (req_payload_offset == 12'd0) begin
                     stat_in = ffha_pkg::ST_NULL_FREE; rv_in = 1'b1;
                  end else if (req_payload_offset[2:0] != 3'd0 || hq[GW]) begin
                     stat_in = ffha_pkg::ST_NOT_BLOCK; rv_in = 1'b1;
                  end else state_in = S_FRD;
               end
            end
         end
         // allocate walk
         S_ARD: begin rd_addr = cur_ff; state_in = S_AWT; end
         S_AWT: begin
            c_in = rd_data;
            if (rd_data.sizeg >= need_ff) begin
               if (rd_data.sizeg > need_ff + SW'(ffha_pkg::HdrG)) begin
                  wr_en = 1'b1; wr_addr = cur_ff + HDR + GW'(need_ff);
                  wr_data.mark = 1'b1; wr_data.freeb = 1'b1;
                  wr_data.sizeg = SW'(nbsz); wr_data.nxt = rd_data.nxt;
                  wr_data.nxt_ok = rd_data.nxt_ok;
                  c_in.nxt = cur_ff + HDR + GW'(need_ff); c_in.nxt_ok = 1'b1;
                  c_in.sizeg = need_ff;
               end
               state_in = S_ACUR;
            end else if (rd_data.nxt_ok) begin
               prev_in = cur_ff; hasp_in = 1'b1; cur_in = rd_data.nxt; state_in = S_ARD;
            end else begin
               stat_in = ffha_pkg::ST_NO_FIT; rv_in = 1'b1; state_in = S_IDLE;
            end
         end
         S_ACUR: begin
            wr_en = 1'b1; wr_addr = cur_ff; wr_data = c_ff; wr_data.freeb = 1'b0;
            goff_in = {cur_ff + HDR, 3'b000}; stat_in = ffha_pkg::ST_OK;
            if (hasp_ff) state_in = S_APRD;
            else begin
               if (c_ff.nxt_ok) head_in = c_ff.nxt; else empty_in = 1'b1;
               rv_in = 1'b1; state_in = S_IDLE;
            end
         end
         S_APRD: begin rd_addr = prev_ff; state_in = S_APWT; end
         S_APWT: begin
            wr_en = 1'b1; wr_addr = prev_ff; wr_data = rd_data;
            wr_data.nxt = c_ff.nxt; wr_data.nxt_ok = c_ff.nxt_ok;
            rv_in = 1'b1; state_in = S_IDLE;
         end
         // free
         S_FRD: begin rd_addr = h_ff; state_in = S_FWT; end
         S_FWT: begin
            hh_in = rd_data; hh_in.freeb = 1'b1;
            if (!rd_data.mark) begin
               stat_in = ffha_pkg::ST_NOT_BLOCK; rv_in = 1'b1; state_in = S_IDLE;
            end else if (rd_data.freeb) begin
               stat_in = ffha_pkg::ST_DBL_FREE; rv_in = 1'b1; state_in = S_IDLE;
            end else begin
               stat_in = ffha_pkg::ST_OK;
               if (empty_ff) begin
                  wr_en = 1'b1; wr_addr = h_ff; wr_data = rd_data;
                  wr_data.freeb = 1'b1; wr_data.nxt_ok = 1'b0;
                  head_in = h_ff; empty_in = 1'b0; rv_in = 1'b1; state_in = S_IDLE;
               end else begin
                  curok_in = 1'b1; state_in = S_WRD;
               end
            end
         end
         S_WRD: begin rd_addr = cur_ff; state_in = S_WWT; end
         S_WWT: begin
            if (cur_ff <= h_ff) begin
               prev_in = cur_ff; hasp_in = 1'b1;
               if (rd_data.nxt_ok) begin cur_in = rd_data.nxt; state_in = S_WRD; end
               else begin curok_in = 1'b0; state_in = S_HWR; end
            end else begin
               c_in = rd_data; state_in = S_NWT;
            end
         end
         S_NRD: state_in = S_NWT;
         S_NWT: begin
            if (hend == (GW+SW+1)'(cur_ff)) begin
               hh_in.sizeg = hh_ff.sizeg + SW'(ffha_pkg::HdrG) + c_ff.sizeg;
               hh_in.nxt = c_ff.nxt; hh_in.nxt_ok = c_ff.nxt_ok;
               wr_en = 1'b1; wr_addr = cur_ff; wr_data = c_ff;
               wr_data.mark = 1'b0; wr_data.freeb = 1'b0;
            end else begin
               hh_in.nxt = cur_ff; hh_in.nxt_ok = 1'b1;
            end
            state_in = S_HWR2;
         end
         S_HWR: begin
            hh_in.nxt = cur_ff; hh_in.nxt_ok = 1'b0; state_in = S_HWR2;
         end
         S_HWR2: begin
            wr_en = 1'b1; wr_addr = h_ff; wr_data = hh_ff;
            if (hasp_ff) state_in = S_PRD;
            else begin head_in = h_ff; rv_in = 1'b1; state_in = S_IDLE; end
         end
         S_PRD: begin rd_addr = prev_ff; state_in = S_PWT; end
         S_PWT: begin
            wr_en = 1'b1; wr_addr = prev_ff; wr_data = rd_data;
            if (pend == (GW+SW+1)'(h_ff)) begin
               wr_data.sizeg = rd_data.sizeg + SW'(ffha_pkg::HdrG) + hh_ff.sizeg;
               wr_data.nxt = hh_ff.nxt; wr_data.nxt_ok = hh_ff.nxt_ok;
               state_in = S_PWR2;
            end else begin
               wr_data.nxt = h_ff; wr_data.nxt_ok = 1'b1;
               rv_in = 1'b1; state_in = S_IDLE;
            end
         end
         S_PWR2: begin
            wr_en = 1'b1; wr_addr = h_ff; wr_data = hh_ff;
            wr_data.mark = 1'b0; wr_data.freeb = 1'b0;
            rv_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold control state, clear on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR; clr_ff <= '0; head_ff <= '0; empty_ff <= 1'b0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; head_ff <= head_in;
         empty_ff <= empty_in; rv_ff <= rv_in;
      end
   end

   // advance payload registers
   always_ff @(posedge clock) begin
      cur_ff <= cur_in; prev_ff <= prev_in; h_ff <= h_in; hasp_ff <= hasp_in;
      curok_ff <= curok_in; need_ff <= need_in; c_ff <= c_in; hh_ff <= hh_in;
      goff_ff <= goff_in; stat_ff <= stat_in;
   end

   `ASSERT_IMP(a_no_accept_busy, clock, reset, state_ff != S_IDLE, !req_ready)
   `ASSERT_IMP(a_goff_only_ok, clock, reset, rv_ff && stat_ff != ffha_pkg::ST_OK,
               goff_ff == 12'd0)
   `ASSERT_NXT(a_rsp_holds, clock, reset, rv_ff && !rsp_ready, rv_ff && $stable(stat_ff))
endmodule

[rtl/core/ffha_hdr_ram.sv]
// Header store: one-port-write, one-port-read RAM with registered read data
module ffha_hdr_ram (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [ffha_pkg::GW-1:0] wr_addr,
   input  ffha_pkg::hdr_type       wr_data,
   input  logic [ffha_pkg::GW-1:0] rd_addr,
   output ffha_pkg::hdr_type       rd_data
);
   ffha_pkg::hdr_type mem [ffha_pkg::Ng];

   // write, and read registered; a read of the written address returns the old data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
